// ----- design/mm4_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;
  localparam int DATA_W    = 32;
  localparam int INDEX_W   = 4;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int IDX_W     = $clog2(DIM);
  localparam int ACC_W     = 2 * DATA_W + $clog2(DIM) + 1;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
  } operand_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [INDEX_W-1:0]       product_index;
    logic                     last_element;
  } product_t;

  typedef struct packed {
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  a_addr;
    logic [ADDR_W-1:0]  b_addr;
    logic               first;
    logic               last;
    logic [INDEX_W-1:0] index;
    logic               last_elem;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/mm4_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm4_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              operands_valid,
  output logic                   operands_ready,
  input  wire mm4_pkg::dp_status_t status,
  output mm4_pkg::ctrl_cmd_t     cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_WAIT  = 2'd2;

  localparam logic [mm4_pkg::ADDR_W-1:0] LAST_CELL = mm4_pkg::ADDR_W'(mm4_pkg::CELLS - 1);
  localparam logic [mm4_pkg::IDX_W-1:0]  LAST_IDX  = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);
  localparam logic [mm4_pkg::ADDR_W-1:0] DIM_A     = mm4_pkg::ADDR_W'(mm4_pkg::DIM);

  logic [1:0]                   state, state_next;
  logic [mm4_pkg::ADDR_W-1:0]   load_count, load_count_next;
  logic [mm4_pkg::IDX_W-1:0]    row, row_next;
  logic [mm4_pkg::IDX_W-1:0]    col, col_next;
  logic [mm4_pkg::IDX_W-1:0]    k, k_next;
  logic                         issue;
  logic                         accept;
  logic [mm4_pkg::ADDR_W-1:0]   elem;

  assign operands_ready = (state == S_LOAD);
  assign accept         = operands_valid && operands_ready;
  assign issue          = (state == S_ISSUE) && ((k != '0) || !status.out_valid);
  assign elem           = mm4_pkg::ADDR_W'(row) * DIM_A + mm4_pkg::ADDR_W'(col);

  always_comb begin
    cmd.wr_en     = accept;
    cmd.wr_addr   = load_count;
    cmd.rd_en     = issue;
    cmd.a_addr    = mm4_pkg::ADDR_W'(row) * DIM_A + mm4_pkg::ADDR_W'(k);
    cmd.b_addr    = mm4_pkg::ADDR_W'(k) * DIM_A + mm4_pkg::ADDR_W'(col);
    cmd.first     = (k == '0);
    cmd.last      = (k == LAST_IDX);
    cmd.index     = mm4_pkg::INDEX_W'(elem);
    cmd.last_elem = (elem == LAST_CELL);
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    row_next        = row;
    col_next        = col;
    k_next          = k;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (load_count == LAST_CELL) begin
            load_count_next = '0;
            row_next        = '0;
            col_next        = '0;
            k_next          = '0;
            state_next      = S_ISSUE;
          end else begin
            load_count_next = load_count + 1'b1;
          end
        end
      end
      S_ISSUE: begin
        if (issue) begin
          if (k == LAST_IDX) begin
            k_next     = '0;
            state_next = S_WAIT;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      S_WAIT: begin
        if (status.out_valid) begin
          if (row == LAST_IDX && col == LAST_IDX) begin
            state_next = S_LOAD;
          end else begin
            state_next = S_ISSUE;
            if (col == LAST_IDX) begin
              col_next = '0;
              row_next = row + 1'b1;
            end else begin
              col_next = col + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      k          <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      row        <= row_next;
      col        <= col_next;
      k          <= k_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/mm4_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm4_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mm4_pkg::operand_t   operands,
  input  wire mm4_pkg::ctrl_cmd_t  cmd,
  output mm4_pkg::dp_status_t      status,
  output logic                     product_valid,
  input  wire logic                product_ready,
  output mm4_pkg::product_t        product
);

  localparam int ACC_W = mm4_pkg::ACC_W;
  localparam int PROD_W = 2 * mm4_pkg::DATA_W;

  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'((65'd1 << mm4_pkg::FRAC_BITS) - 65'd1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - mm4_pkg::DATA_W){1'b0}}, 1'b0, {(mm4_pkg::DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - mm4_pkg::DATA_W){1'b1}}, 1'b1, {(mm4_pkg::DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic                        valid;
    logic                        first;
    logic                        last;
    logic [mm4_pkg::INDEX_W-1:0] index;
    logic                        last_elem;
  } stage_tag_t;

  logic [mm4_pkg::DATA_W-1:0] left_store  [mm4_pkg::CELLS];
  logic [mm4_pkg::DATA_W-1:0] right_store [mm4_pkg::CELLS];

  logic signed [mm4_pkg::DATA_W-1:0] a_rd, b_rd;
  logic signed [PROD_W-1:0]          prod;
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           prod_ext;
  logic signed [ACC_W-1:0]           rounded;
  logic signed [ACC_W-1:0]           quot;
  logic signed [mm4_pkg::DATA_W-1:0] sat_value;
  stage_tag_t                        tag1, tag2, tag3, tag4;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      left_store[cmd.wr_addr]  <= operands.a_value;
      right_store[cmd.wr_addr] <= operands.b_value;
    end
    if (cmd.rd_en) begin
      a_rd <= left_store[cmd.a_addr];
      b_rd <= right_store[cmd.b_addr];
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
  assign rounded  = acc + (acc[ACC_W-1] ? RND_BIAS : '0);

  always_comb begin
    if (quot > SAT_HI) begin
      sat_value = SAT_HI[mm4_pkg::DATA_W-1:0];
    end else if (quot < SAT_LO) begin
      sat_value = SAT_LO[mm4_pkg::DATA_W-1:0];
    end else begin
      sat_value = quot[mm4_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_rd * b_rd;
    if (tag2.valid) begin
      acc <= tag2.first ? prod_ext : acc + prod_ext;
    end
    if (tag3.valid) begin
      quot <= rounded >>> mm4_pkg::FRAC_BITS;
    end
    if (tag4.valid) begin
      product <= {sat_value, tag4.index, tag4.last_elem};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1          <= '0;
      tag2          <= '0;
      tag3          <= '0;
      tag4          <= '0;
      product_valid <= 1'b0;
    end else begin
      tag1 <= {cmd.rd_en, cmd.first, cmd.last, cmd.index, cmd.last_elem};
      tag2 <= tag1;
      tag3 <= {tag2.valid && tag2.last, tag2.first, tag2.last, tag2.index, tag2.last_elem};
      tag4 <= tag3;
      if (tag4.valid) begin
        product_valid <= 1'b1;
      end else if (product_ready) begin
        product_valid <= 1'b0;
      end
    end
  end

  assign status.out_valid = product_valid;

endmodule

`default_nettype wire

// ----- design/matrix4x4_multiply.sv -----
// Fixed-point 4 x 4 matrix multiply, C = A * B, signed Q16.16 throughout.
// The operand channel carries one element of A and one of B per transaction,
// both in row-major order. After the sixteenth operand transaction the block
// computes C and sends its sixteen elements on the product channel in
// row-major order, each with its index, and marks the last one.
// Every element is the exact sum of four products, truncated toward zero to
// Q16.16 and saturated to the signed 32-bit range.
// The block accepts one operand transaction per cycle while loading. Each
// product element then takes four passes through the single shared
// multiply-accumulate, plus memory read, multiply, rounding and saturation.
// The operand channel is closed while C is computed and reopens while the
// last product element may still wait to be taken.
// When the receiver stalls, the current product element holds and the next
// one is not started. Reset returns the block to loading at element zero
// and drops any pending product; the operand stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix4x4_multiply (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              operands_valid,
  output logic                   operands_ready,
  input  wire mm4_pkg::operand_t operands,
  output logic                   product_valid,
  input  wire logic              product_ready,
  output mm4_pkg::product_t      product
);

  mm4_pkg::ctrl_cmd_t cmd;
  mm4_pkg::dp_status_t status;

  mm4_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .operands_valid (operands_valid),
    .operands_ready (operands_ready),
    .status         (status),
    .cmd            (cmd)
  );

  mm4_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .operands      (operands),
    .cmd           (cmd),
    .status        (status),
    .product_valid (product_valid),
    .product_ready (product_ready),
    .product       (product)
  );

endmodule

`default_nettype wire

// ----- design/mm4_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mm4_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              operands_valid,
  input wire logic              operands_ready,
  input wire mm4_pkg::operand_t operands,
  input wire logic              product_valid,
  input wire logic              product_ready,
  input wire mm4_pkg::product_t product
);

  // A stalled product transaction keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    product_valid && !product_ready |=> product_valid && $stable(product))
    else $error("product changed while stalled");

  // Reset leaves the block ready for operands with no product pending.
  assert property (@(posedge clk) rst |=> operands_ready && !product_valid)
    else $error("block not idle after reset");

  // Operands are refused while an element other than the last is pending.
  assert property (@(posedge clk) disable iff (rst)
    product_valid && !product.last_element |-> !operands_ready)
    else $error("operands taken during computation");

  // Operands may be accepted while a product is pending only if it is the last element.
  assert property (@(posedge clk) disable iff (rst)
    operands_valid && operands_ready && product_valid |-> product.last_element)
    else $error("operands accepted while a run was unfinished");

endmodule

bind matrix4x4_multiply mm4_checker u_checker (.*);

`default_nettype wire
